/* hdl/rtr_pkg.sv */
package rtr_pkg;

   // register reset values
   localparam logic [15:0] EXP_DEFAULT     = 16'd11703;
   localparam logic [31:0] RATE_COEF_RESET = 32'd14316557;
   localparam logic [15:0] BAD_VALUE_RESET = 16'h8000;

   // 0.1 * log2(10) in Q.24
   localparam logic signed [23:0] LOG_K = 24'sd5573271;

   // width of the signed power-of-two integer part
   localparam int EXP_W = 10;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_EXPONENT_SCALE   = 2'd0,
      CSR_RATE_COEFFICIENT = 2'd1,
      CSR_BAD_VALUE        = 2'd2
   } csr_index_type;

   // control that travels with each gate down the pipeline
   typedef struct packed {
      logic valid;
      logic in_mask;
      logic bad;
      logic last;
   } rtr_side_type;

   // floor integer square root of a 64-bit value, elaboration use only
   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bit_v;
      x     = x_in;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (x >= res + bit_v) begin
            x   = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // table entry k: 2^(k / 2^bits) in Q2.30, built from chained square roots
   function automatic logic [31:0] frac_pow2(input int unsigned k, input int unsigned bits);
      logic [63:0] root;
      logic [63:0] acc;
      logic [31:0] result;
      root = isqrt64(64'd1 << 61);
      acc  = 64'd1 << 30;
      for (int unsigned i = 1; i <= bits; i++) begin
         if (((k >> (bits - i)) & 1) != 0) begin
            acc = (acc * root + (64'd1 << 29)) >> 30;
         end
         root = isqrt64(root << 30);
      end
      if ((k >> bits) != 0) begin
         result = 32'h8000_0000;
      end else begin
         result = acc[31:0];
      end
      return result;
   endfunction

endpackage

/* hdl/rtr_pow2_frac.sv */
module rtr_pow2_frac import rtr_pkg::*; #(
   parameter int FRAC_TABLE_BITS = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rtr_side_type                     in_side,
   input  logic [FRAC_TABLE_BITS-1:0]       in_idx,
   input  logic [16-FRAC_TABLE_BITS-1:0]    in_rem,
   input  logic signed [EXP_W-1:0]          in_exp,
   output rtr_side_type                     out_side,
   output logic [31:0]                      out_mant,
   output logic signed [EXP_W-1:0]          out_exp
);

   localparam int REM_BITS  = 16 - FRAC_TABLE_BITS;
   localparam int FRAC_SIZE = 2 ** FRAC_TABLE_BITS;

   // fractional power-of-two table, one extra entry for interpolation
   logic [31:0] rom_tbl [FRAC_SIZE+1];

   for (genvar k = 0; k <= FRAC_SIZE; k++) begin : g_rom
      localparam logic [31:0] ENTRY = frac_pow2(k, FRAC_TABLE_BITS);
      assign rom_tbl[k] = ENTRY;
   end

   logic [FRAC_TABLE_BITS:0]    lo_addr;
   logic [FRAC_TABLE_BITS:0]    hi_addr;
   rtr_side_type                side_a_ff;
   logic [31:0]                 lo_ff;
   logic [31:0]                 diff_ff;
   logic [REM_BITS-1:0]         rem_ff;
   logic signed [EXP_W-1:0]     exp_a_ff;
   logic [31+REM_BITS:0]        prod;
   logic [31:0]                 mant_in;
   rtr_side_type                side_b_ff;
   logic [31:0]                 mant_ff;
   logic signed [EXP_W-1:0]     exp_b_ff;

   assign lo_addr = {1'b0, in_idx};
   assign hi_addr = lo_addr + 1'b1;

   // table read: base entry and step to the next one
   always_ff @(posedge clock) begin
      if (reset) begin
         side_a_ff <= '0;
      end else begin
         side_a_ff <= in_side;
      end
      lo_ff    <= rom_tbl[lo_addr];
      diff_ff  <= rom_tbl[hi_addr] - rom_tbl[lo_addr];
      rem_ff   <= in_rem;
      exp_a_ff <= in_exp;
   end

   // linear interpolation, truncating
   always_comb begin
      prod    = diff_ff * rem_ff;
      mant_in = lo_ff + prod[31+REM_BITS:REM_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_b_ff <= '0;
      end else begin
         side_b_ff <= side_a_ff;
      end
      mant_ff  <= mant_in;
      exp_b_ff <= exp_a_ff;
   end

   assign out_side = side_b_ff;
   assign out_mant = mant_ff;
   assign out_exp  = exp_b_ff;

endmodule

/* hdl/reflectivity_to_rain_rate.sv */
// Z-R rain rate: each gate's dBZ (signed Q8.8) becomes A * 10^(dBZ * X / 10) in
// unsigned Q24.8, saturating at all ones. The block is a nine-stage pipeline
// that accepts one gate on every clock: busy stays low, and each gate's result
// passes through stages 0 to 8 in order and then is on the rsp_ ports.
// Results leave in arrival order and cannot be held off, so none is ever
// stalled. The depth comes from the two multiplies that form the exponent,
// the table read and interpolation, the coefficient multiply and the final
// shift, round and clamp. csr_ready is always high; write the registers only
// while no gate is in flight. A gate outside the mask returns written low and
// a zero rate; an in-mask gate equal to bad_value gives bad_flag and zero rate.
module reflectivity_to_rain_rate import rtr_pkg::*; #(
   parameter int FRAC_TABLE_BITS = 6
) (
   input  logic               clock,
   input  logic               reset,
   // gate input
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_gate_dbz,
   input  logic               req_in_boundary,
   input  logic               req_last_gate,
   // result output
   output logic               rsp_valid,
   output logic [31:0]        rsp_rain_rate,
   output logic               rsp_bad_flag,
   output logic               rsp_written,
   output logic               rsp_saturated,
   output logic               rsp_last_out,
   // configuration write
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int REM_BITS = 16 - FRAC_TABLE_BITS;
   localparam int FRAC_MSB = 45;
   localparam int LATENCY  = 9;

   logic                    accept;
   logic [15:0]             exponent_ff;
   logic [31:0]             coef_ff;
   logic [15:0]             bad_value_ff;
   logic [15:0]             x_sel;

   rtr_side_type            side0_ff, side1_ff, side2_ff, side3_ff;
   rtr_side_type            side5, side6_ff, side7_ff;
   logic signed [15:0]      dbz_ff;
   logic signed [32:0]      p_in;
   logic signed [31:0]      p_ff;
   logic signed [55:0]      v_in;
   logic signed [55:0]      v_ff;
   logic signed [55:0]      w;
   logic [FRAC_TABLE_BITS-1:0] idx_ff;
   logic [REM_BITS-1:0]     rem_ff;
   logic signed [EXP_W-1:0] n_ff;
   logic [31:0]             mant5;
   logic signed [EXP_W-1:0] n5;
   logic [63:0]             m_in;
   logic [63:0]             m_ff;
   logic signed [10:0]      e_in;
   logic signed [10:0]      e_ff;
   logic                    m_nz;
   logic [5:0]              sh_l;
   logic signed [10:0]      neg_e;
   logic [5:0]              rnd_pos;
   logic [63:0]             q_in;
   logic                    rnd_in;
   logic                    ovf_in;
   logic [63:0]             q_ff;
   logic                    rnd_ff;
   logic                    ovf_ff;
   logic [63:0]             r_sum;
   logic                    sat_in;
   logic [31:0]             rate_in;
   logic                    rsp_valid_ff;
   logic [31:0]             rate_ff;
   logic                    bad_ff;
   logic                    written_ff;
   logic                    sat_ff;
   logic                    last_ff;

   // the pipeline never stalls
   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff  <= EXP_DEFAULT;
         coef_ff      <= RATE_COEF_RESET;
         bad_value_ff <= BAD_VALUE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXPONENT_SCALE:   exponent_ff  <= csr_wdata[15:0];
            CSR_RATE_COEFFICIENT: coef_ff      <= csr_wdata;
            CSR_BAD_VALUE:        bad_value_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign x_sel = (exponent_ff == '0) ? EXP_DEFAULT : exponent_ff;

   // stage 0: capture the transaction and flag the missing-data code
   always_ff @(posedge clock) begin
      if (reset) begin
         side0_ff <= '0;
      end else begin
         side0_ff.valid   <= accept;
         side0_ff.in_mask <= req_in_boundary;
         side0_ff.bad     <= req_in_boundary && (req_gate_dbz == bad_value_ff);
         side0_ff.last    <= req_last_gate;
      end
      dbz_ff <= req_gate_dbz;
   end

   // stage 1: dBZ times exponent
   assign p_in = dbz_ff * $signed({1'b0, x_sel});

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff <= '0;
      end else begin
         side1_ff <= side0_ff;
      end
      p_ff <= p_in[31:0];
   end

   // stage 2: scale into a base-two exponent
   assign v_in = p_ff * LOG_K;

   always_ff @(posedge clock) begin
      if (reset) begin
         side2_ff <= '0;
      end else begin
         side2_ff <= side1_ff;
      end
      v_ff <= v_in;
   end

   // stage 3: round to Q.16, split into integer and table index / remainder
   assign w = v_ff + (56'sd1 <<< 29);

   always_ff @(posedge clock) begin
      if (reset) begin
         side3_ff <= '0;
      end else begin
         side3_ff <= side2_ff;
      end
      idx_ff <= w[FRAC_MSB -: FRAC_TABLE_BITS];
      rem_ff <= w[FRAC_MSB-FRAC_TABLE_BITS -: REM_BITS];
      n_ff   <= w[55:46];
   end

   // stages 4 and 5: fractional power of two
   rtr_pow2_frac #(
      .FRAC_TABLE_BITS(FRAC_TABLE_BITS)
   ) u_pow2_frac (
      .clock   (clock),
      .reset   (reset),
      .in_side (side3_ff),
      .in_idx  (idx_ff),
      .in_rem  (rem_ff),
      .in_exp  (n_ff),
      .out_side(side5),
      .out_mant(mant5),
      .out_exp (n5)
   );

   // stage 6: coefficient multiply and final shift count
   assign m_in = coef_ff * mant5;
   assign e_in = $signed({n5[EXP_W-1], n5}) - 11'sd54;

   always_ff @(posedge clock) begin
      if (reset) begin
         side6_ff <= '0;
      end else begin
         side6_ff <= side5;
      end
      m_ff <= m_in;
      e_ff <= e_in;
   end

   // stage 7: shift left with overflow check, or right keeping the round bit
   always_comb begin
      m_nz    = |m_ff;
      sh_l    = 6'd32 - {1'b0, e_ff[4:0]};
      neg_e   = -e_ff;
      rnd_pos = neg_e[5:0] - 6'd1;
      q_in    = '0;
      rnd_in  = 1'b0;
      ovf_in  = 1'b0;
      if (!e_ff[10]) begin
         if (e_ff >= 11'sd32) begin
            ovf_in = m_nz;
         end else begin
            ovf_in = (m_ff >> sh_l) != '0;
            q_in   = {32'b0, m_ff[31:0] << e_ff[4:0]};
         end
      end else if (neg_e < 11'sd64) begin
         q_in   = m_ff >> neg_e[5:0];
         rnd_in = m_ff[rnd_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side7_ff <= '0;
      end else begin
         side7_ff <= side6_ff;
      end
      q_ff   <= q_in;
      rnd_ff <= rnd_in;
      ovf_ff <= ovf_in;
   end

   // stage 8: round half up, clamp, and zero masked-out or bad gates
   always_comb begin
      r_sum   = q_ff + {63'b0, rnd_ff};
      sat_in  = ovf_ff || (r_sum[63:32] != '0);
      rate_in = sat_in ? '1 : r_sum[31:0];
      if (!side7_ff.in_mask || side7_ff.bad) begin
         sat_in  = 1'b0;
         rate_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= side7_ff.valid;
      end
      rate_ff    <= rate_in;
      bad_ff     <= side7_ff.bad;
      written_ff <= side7_ff.in_mask;
      sat_ff     <= sat_in;
      last_ff    <= side7_ff.last;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rain_rate = rate_ff;
   assign rsp_bad_flag  = bad_ff;
   assign rsp_written   = written_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_last_out  = last_ff;

   // every accepted gate comes out after the fixed pipeline depth
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("gate result missing after pipeline latency");

   // clamping only happens on a written, good gate
   a_sat_gate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_written && !rsp_bad_flag))
      else $error("saturation flagged on masked or bad gate");

   // a clamped rate is all ones
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_rain_rate == '1))
      else $error("saturated rate not at maximum");

   // masked-out or bad gates carry no rate
   a_zero_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (!rsp_written || rsp_bad_flag)) |-> (rsp_rain_rate == '0))
      else $error("nonzero rate on masked or bad gate");

endmodule

/* sim/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rtr_pkg::*;

   // shadow reset values and arithmetic constants for the rate predictor
   localparam int              FRAC_BITS         = 6;
   localparam int              TABLE_LEN         = 1 << FRAC_BITS;
   localparam logic [15:0]     RESET_EXPONENT    = 16'd11703;
   localparam logic [31:0]     RESET_COEFFICIENT = 32'd14316557;
   localparam logic [15:0]     RESET_BAD_VALUE   = 16'h8000;
   localparam longint          LOG2_TENTH_Q24    = 5573271;
   localparam logic [1:0]      CSR_INDEX_SPARE   = 2'd3;
   localparam int              GATES_PER_PHASE   = 140;
   localparam int              DRAIN_CYCLES      = 12;
   localparam int              STALL_LIMIT       = 1000;

   // one result of the block
   typedef struct packed {
      logic [31:0] rain_rate;
      logic        bad_flag;
      logic        written;
      logic        saturated;
      logic        last_out;
   } rain_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_gate_dbz = '0;
   logic               req_in_boundary = 1'b0;
   logic               req_last_gate = 1'b0;
   logic               rsp_valid;
   logic [31:0]        rsp_rain_rate;
   logic               rsp_bad_flag;
   logic               rsp_written;
   logic               rsp_saturated;
   logic               rsp_last_out;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   // register shadows
   logic [15:0]        cfg_exponent    = RESET_EXPONENT;
   logic [31:0]        cfg_coefficient = RESET_COEFFICIENT;
   logic [15:0]        cfg_bad_value   = RESET_BAD_VALUE;

   // fractional power-of-two table, Q2.30
   longint unsigned    pow2_frac [0:TABLE_LEN];

   rain_result_type    pending_rain [$];
   bit                 gaps_on = 1'b1;
   int                 mismatches = 0;
   int                 gates_sent = 0;
   int                 results_checked = 0;
   int                 csr_writes = 0;
   int                 sat_seen = 0;
   int                 bad_seen = 0;
   int                 outside_seen = 0;

   reflectivity_to_rain_rate #(
      .FRAC_TABLE_BITS(FRAC_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_gate_dbz    (req_gate_dbz),
      .req_in_boundary (req_in_boundary),
      .req_last_gate   (req_last_gate),
      .rsp_valid       (rsp_valid),
      .rsp_rain_rate   (rsp_rain_rate),
      .rsp_bad_flag    (rsp_bad_flag),
      .rsp_written     (rsp_written),
      .rsp_saturated   (rsp_saturated),
      .rsp_last_out    (rsp_last_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #2 clock = ~clock;

   // one line per mismatch
   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   // floor square root, bit by bit
   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned res;
      longint unsigned cand;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
         cand = res | (longint'(1) << b);
         if (cand * cand <= x) begin
            res = cand;
         end
      end
      return res;
   endfunction

   // expected result for one gate under the current register shadows
   function automatic rain_result_type predict_rain_rate(input logic signed [15:0] dbz,
                                                         input logic inb, input logic last);
      rain_result_type r;
      logic [15:0]     xs;
      longint          prod;
      longint unsigned biased;
      logic [15:0]     frac;
      longint          pow_int;
      longint          shift_e;
      int unsigned     tidx;
      longint unsigned rem;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned interp;
      longint unsigned mant;
      longint unsigned wide;
      r = '0;
      r.written  = inb;
      r.last_out = last;
      if (inb && dbz == cfg_bad_value) begin
         r.bad_flag = 1'b1;
      end else if (inb) begin
         xs      = (cfg_exponent == 16'd0) ? RESET_EXPONENT : cfg_exponent;
         prod    = longint'(dbz) * longint'(xs) * LOG2_TENTH_Q24;
         biased  = longint'(prod + (longint'(1) << 29) + (longint'(1) << 60)) >> 30;
         frac    = biased[15:0];
         pow_int = longint'(biased >> 16) - 16384;
         tidx    = frac >> (16 - FRAC_BITS);
         rem     = frac & ((16'd1 << (16 - FRAC_BITS)) - 16'd1);
         lo      = pow2_frac[tidx];
         hi      = pow2_frac[tidx + 1];
         interp  = lo + (((hi - lo) * rem) >> (16 - FRAC_BITS));
         mant    = longint'(cfg_coefficient) * interp;
         shift_e = pow_int - 54;
         if (mant == 0) begin
            r.rain_rate = '0;
         end else if (shift_e >= 0) begin
            if (shift_e >= 32 || mant > (64'hFFFF_FFFF >> shift_e)) begin
               r.rain_rate = 32'hFFFF_FFFF;
               r.saturated = 1'b1;
            end else begin
               r.rain_rate = 32'(mant << shift_e);
            end
         end else if (-shift_e < 64) begin
            // round half up on the way down
            wide = (mant >> (-shift_e)) + ((mant >> (-shift_e - 1)) & 64'd1);
            if (wide > 64'hFFFF_FFFF) begin
               r.rain_rate = 32'hFFFF_FFFF;
               r.saturated = 1'b1;
            end else begin
               r.rain_rate = wide[31:0];
            end
         end
      end
      return r;
   endfunction

   // random dbz, weighted toward the interesting regions
   function automatic logic signed [15:0] pick_dbz();
      int unsigned roll;
      int          v;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         v = int'($urandom_range(0, 26880)) - 7680;
      end else if (roll < 75) begin
         v = int'($urandom);
      end else if (roll < 85) begin
         v = int'(cfg_bad_value);
      end else if (roll < 95) begin
         case ($urandom_range(0, 6))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2: v = 16'h8001;
            3: v = 0;
            4: v = 1;
            5: v = 16'hFFFF;
            default: v = 16'h7F00;
         endcase
      end else begin
         v = int'($urandom_range(20000, 32767));
      end
      return 16'(v);
   endfunction

   // wait for every outstanding result with the input idle
   task automatic wait_drained();
      @(negedge clock) start <= 1'b0;
      while (pending_rain.size() != 0) @(posedge clock);
   endtask

   // register write transaction, only with the pipeline empty
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_EXPONENT_SCALE:   cfg_exponent    = data[15:0];
         CSR_RATE_COEFFICIENT: cfg_coefficient = data;
         CSR_BAD_VALUE:        cfg_bad_value   = data[15:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // one gate transaction, with random idle cycles in front
   task automatic send_gate(input logic signed [15:0] dbz, input logic inb,
                            input logic last);
      // each idle cycle drops start for one clock
      while (gaps_on && $urandom_range(0, 99) < 18) begin
         @(negedge clock) start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_gate_dbz    <= dbz;
      req_in_boundary <= inb;
      req_last_gate   <= last;
      do @(posedge clock); while (busy);
      pending_rain.push_back(predict_rain_rate(dbz, inb, last));
      gates_sent++;
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin : check_rain
      rain_result_type got;
      rain_result_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_rain_rate, rsp_bad_flag, rsp_written, rsp_saturated, rsp_last_out};
         if (pending_rain.size() == 0) begin
            flag_mismatch($sformatf("unexpected result rate %h", got.rain_rate));
         end else begin
            want = pending_rain.pop_front();
            if (got.rain_rate !== want.rain_rate || got.bad_flag !== want.bad_flag ||
                got.written !== want.written || got.saturated !== want.saturated ||
                got.last_out !== want.last_out) begin
               flag_mismatch($sformatf(
                  "result %0d rate %h/%h bad %b/%b wr %b/%b sat %b/%b last %b/%b (got/exp)",
                  results_checked, got.rain_rate, want.rain_rate, got.bad_flag,
                  want.bad_flag, got.written, want.written, got.saturated,
                  want.saturated, got.last_out, want.last_out));
            end
            sat_seen     += want.saturated;
            bad_seen     += want.bad_flag;
            outside_seen += !want.written;
         end
         results_checked++;
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // extremes of the gate fields under reset registers
   task automatic test_field_extremes();
      send_gate(16'sh7FFF, 1'b1, 1'b0);
      send_gate(16'sh8000, 1'b1, 1'b0);   // bad gate inside mask
      send_gate(16'sh8001, 1'b1, 1'b0);   // underflows to zero
      send_gate(16'sh0000, 1'b1, 1'b0);
      send_gate(16'sh0001, 1'b1, 1'b0);
      send_gate(16'shFFFF, 1'b1, 1'b0);
      send_gate(16'sh2800, 1'b1, 1'b1);
      send_gate(16'sh8000, 1'b0, 1'b0);   // bad value outside mask
      send_gate(16'sh2800, 1'b0, 1'b1);
   endtask

   // zero exponent selects the default, then the extremes
   task automatic test_exponent_register();
      write_csr(CSR_EXPONENT_SCALE, 32'hA5A5_0000);
      send_gate(16'sh2800, 1'b1, 1'b0);
      write_csr(CSR_EXPONENT_SCALE, 32'h0000_FFFF);
      send_gate(16'sh7FFF, 1'b1, 1'b0);   // overflow clamps
      send_gate(16'sh8001, 1'b1, 1'b1);
      write_csr(CSR_EXPONENT_SCALE, 32'h0000_0001);
      send_gate(16'sh7FFF, 1'b1, 1'b0);
      write_csr(CSR_EXPONENT_SCALE, {16'h0000, RESET_EXPONENT});
   endtask

   // zero and full-scale coefficient
   task automatic test_coefficient_register();
      write_csr(CSR_RATE_COEFFICIENT, 32'h0000_0000);
      send_gate(16'sh7FFF, 1'b1, 1'b0);
      write_csr(CSR_RATE_COEFFICIENT, 32'hFFFF_FFFF);
      send_gate(16'sh7FFF, 1'b1, 1'b0);
      send_gate(16'sh0000, 1'b1, 1'b0);
      write_csr(CSR_RATE_COEFFICIENT, RESET_COEFFICIENT);
   endtask

   // moved missing-data code, old code becomes ordinary data
   task automatic test_bad_value_register();
      write_csr(CSR_BAD_VALUE, 32'h5A5A_0000);
      send_gate(16'sh0000, 1'b1, 1'b0);
      send_gate(16'sh0000, 1'b0, 1'b0);
      send_gate(16'sh8000, 1'b1, 1'b0);
      write_csr(CSR_BAD_VALUE, 32'h0000_7FFF);
      send_gate(16'sh7FFF, 1'b1, 1'b1);
      write_csr(CSR_BAD_VALUE, {16'h0000, RESET_BAD_VALUE});
   endtask

   // write to the spare index must change nothing
   task automatic test_spare_index();
      write_csr(CSR_INDEX_SPARE, 32'hFFFF_FFFF);
      send_gate(16'sh2800, 1'b1, 1'b0);
   endtask

   // random gates over several register settings
   task automatic test_random_gates();
      int unsigned roll;
      logic [15:0] exp_val;
      logic [31:0] coef_val;
      logic [15:0] bad_val;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               exp_val  = RESET_EXPONENT;
               coef_val = RESET_COEFFICIENT;
               bad_val  = RESET_BAD_VALUE;
            end
            4: begin
               exp_val  = 16'hFFFF;
               coef_val = 32'hFFFF_FFFF;
               bad_val  = 16'h7FFF;
            end
            5: begin
               exp_val  = 16'h0001;
               coef_val = 32'h0000_0001;
               bad_val  = 16'h0000;
            end
            default: begin
               roll = $urandom_range(0, 99);
               if (roll < 10)      exp_val = 16'h0000;
               else if (roll < 20) exp_val = 16'hFFFF;
               else if (roll < 60) exp_val = 16'($urandom_range(6000, 20000));
               else                exp_val = 16'($urandom);
               roll = $urandom_range(0, 99);
               if (roll < 10)      coef_val = 32'h0000_0000;
               else if (roll < 20) coef_val = 32'hFFFF_FFFF;
               else if (roll < 60) coef_val = $urandom_range(1000000, 100000000);
               else                coef_val = $urandom;
               bad_val = ($urandom_range(0, 99) < 40) ? RESET_BAD_VALUE : 16'($urandom);
            end
         endcase
         write_csr(CSR_EXPONENT_SCALE, {16'($urandom), exp_val});
         write_csr(CSR_RATE_COEFFICIENT, coef_val);
         write_csr(CSR_BAD_VALUE, {16'($urandom), bad_val});
         // one phase runs back to back with no gaps
         gaps_on = (phase != 2);
         for (int i = 0; i < GATES_PER_PHASE; i++) begin
            send_gate(pick_dbz(), $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 10);
         end
      end
      gaps_on = 1'b1;
   endtask

   // test sequence
   initial begin
      longint unsigned root;
      longint unsigned acc;
      // 2^(k/2^B) from chained square roots, last entry exactly 2
      for (int k = 0; k <= TABLE_LEN; k++) begin
         root = floor_sqrt(longint'(1) << 61);
         acc  = longint'(1) << 30;
         for (int i = 1; i <= FRAC_BITS; i++) begin
            if (((k >> (FRAC_BITS - i)) & 1) != 0) begin
               acc = (acc * root + (longint'(1) << 29)) >> 30;
            end
            root = floor_sqrt(root << 30);
         end
         pow2_frac[k] = (k == TABLE_LEN) ? (longint'(1) << 31) : acc;
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_field_extremes();
      test_exponent_register();
      test_coefficient_register();
      test_bad_value_register();
      test_spare_index();
      test_random_gates();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rain.size() != 0) begin
         flag_mismatch($sformatf("%0d results never arrived", pending_rain.size()));
      end

      $display("sent %0d gates over %0d register writes, checked %0d results",
               gates_sent, csr_writes, results_checked);
      $display("expected %0d clamped, %0d missing-data, %0d outside mask; %0d mismatches",
               sat_seen, bad_seen, outside_seen, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
